FILE: src/sfu_pkg.sv
// ----------------------------------------------------------------------------
// sfu_pkg: shared types and constants for the serial frame unescape unit
// Holds the configuration register map, mode codes and the beat structs
// passed between the decode core, the result queue and the top level.
// ----------------------------------------------------------------------------
package sfu_pkg;

  // byte width of the stream and of the length fields
  localparam int unsigned ByteW = 8;

  // xor mask applied to the byte that follows an escape
  localparam logic [ByteW-1:0] EscXor = 8'h20;

  // configuration register map
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAMING_MODE = 3'd0,
    REG_ESCAPE_BYTE  = 3'd1,
    REG_CODE_A       = 3'd2,
    REG_CODE_B       = 3'd3,
    REG_CODE_C       = 3'd4
  } sfu_reg_e;

  // framing mode codes, the unused code behaves as raw
  typedef enum logic [1:0] {
    MODE_AUTO   = 2'd0,
    MODE_FRAMED = 2'd1,
    MODE_RAW    = 2'd2
  } sfu_mode_e;

  // reset values of the configuration registers
  localparam logic [1:0]       ModeReset   = MODE_AUTO;
  localparam logic [ByteW-1:0] EscapeReset = 8'd125;
  localparam logic [ByteW-1:0] CodeAReset  = 8'd64;
  localparam logic [ByteW-1:0] CodeBReset  = 8'd65;
  localparam logic [ByteW-1:0] CodeCReset  = 8'd66;

  // live configuration seen by the core
  typedef struct packed {
    logic [1:0]       mode;
    logic [ByteW-1:0] escape;
    logic [ByteW-1:0] code_a;
    logic [ByteW-1:0] code_b;
    logic [ByteW-1:0] code_c;
  } sfu_cfg_t;

  // one result beat
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } sfu_beat_t;

  // results produced by one input beat, first beat in slot 0
  typedef struct packed {
    logic [1:0] num;
    sfu_beat_t  beat1;
    sfu_beat_t  beat0;
  } sfu_res_t;

endpackage

FILE: src/sfu_core.sv
// ----------------------------------------------------------------------------
// sfu_core: per-byte decode of framing, header drop and escapes
// Keeps the packet state and turns each accepted input beat into zero,
// one or two result beats in the same cycle.
// ----------------------------------------------------------------------------
module sfu_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [sfu_pkg::ByteW-1:0]     rx_byte_i,
  input  logic                          packet_start_i,
  input  logic [sfu_pkg::ByteW-1:0]     wanted_length_i,
  input  sfu_pkg::sfu_cfg_t             cfg_i,
  output sfu_pkg::sfu_res_t             res_o
);
  import sfu_pkg::*;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_DETECT = 2'd1,
    POS_HEADER = 2'd2,
    POS_BODY   = 2'd3
  } pos_e;

  pos_e             pos_q, pos_d;
  logic [ByteW-1:0] held_q, held_d;
  logic             unframe_q, unframe_d;
  logic             esc_q, esc_d;
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] tgt_q, tgt_d;

  // packet state after an optional restart
  pos_e             pos_s;
  logic [ByteW-1:0] held_s;
  logic             unframe_s;
  logic             esc_s;
  logic [ByteW-1:0] cnt_s;

  // emit requests before the length check
  logic             req0, req1;
  logic [ByteW-1:0] byte0, byte1;
  logic             fire0, fire1;
  logic [ByteW-1:0] cnt_mid;
  logic             code_hit;

  assign code_hit = (rx_byte_i == cfg_i.code_a) || (rx_byte_i == cfg_i.code_b) ||
                    (rx_byte_i == cfg_i.code_c);

  // restart and per-position decode
  always_comb begin
    pos_s     = pos_q;
    held_s    = held_q;
    unframe_s = unframe_q;
    esc_s     = esc_q;
    cnt_s     = cnt_q;
    tgt_d     = tgt_q;
    if (packet_start_i) begin
      pos_s     = POS_FIRST;
      held_s    = '0;
      unframe_s = 1'b0;
      esc_s     = 1'b0;
      cnt_s     = '0;
      tgt_d     = wanted_length_i;
    end

    pos_d     = pos_s;
    held_d    = held_s;
    unframe_d = unframe_s;
    esc_d     = esc_s;
    req0      = 1'b0;
    req1      = 1'b0;
    byte0     = rx_byte_i;
    byte1     = rx_byte_i;

    unique case (pos_s)
      POS_FIRST: begin
        if (tgt_d < ByteW'(2)) begin
          unframe_d = 1'b0;
          pos_d     = POS_BODY;
          req0      = 1'b1;
        end else begin
          unique case (cfg_i.mode)
            MODE_AUTO: begin
              held_d = rx_byte_i;
              pos_d  = POS_DETECT;
            end
            MODE_FRAMED: begin
              unframe_d = 1'b1;
              pos_d     = POS_HEADER;
            end
            default: begin
              unframe_d = 1'b0;
              pos_d     = POS_HEADER;
              req0      = 1'b1;
            end
          endcase
        end
      end
      POS_DETECT: begin
        pos_d = POS_BODY;
        if (code_hit) begin
          unframe_d = 1'b1;
        end else begin
          unframe_d = 1'b0;
          req0      = 1'b1;
          byte0     = held_s;
          req1      = 1'b1;
        end
      end
      POS_HEADER: begin
        pos_d = POS_BODY;
        req0  = !unframe_s;
      end
      POS_BODY: begin
        if (!unframe_s) begin
          req0 = 1'b1;
        end else if (cnt_s < tgt_d) begin
          if (esc_s) begin
            esc_d = 1'b0;
            req0  = 1'b1;
            byte0 = rx_byte_i ^ EscXor;
          end else if (rx_byte_i == cfg_i.escape) begin
            esc_d = 1'b1;
          end else begin
            req0 = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // length limit: each emit takes one count until the target is reached
  always_comb begin
    fire0   = req0 && (cnt_s < tgt_d);
    cnt_mid = fire0 ? cnt_s + ByteW'(1) : cnt_s;
    fire1   = req1 && fire0 && (cnt_mid < tgt_d);
    cnt_d   = fire1 ? cnt_mid + ByteW'(1) : cnt_mid;

    res_o.beat0.data = byte0;
    res_o.beat0.last = (cnt_mid == tgt_d);
    res_o.beat1.data = byte1;
    res_o.beat1.last = (cnt_d == tgt_d);
    res_o.num        = fire1 ? 2'd2 : (fire0 ? 2'd1 : 2'd0);
    if (!accept_i) begin
      res_o.num = 2'd0;
    end
  end

  // packet state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_FIRST;
      held_q    <= '0;
      unframe_q <= 1'b0;
      esc_q     <= 1'b0;
      cnt_q     <= '0;
      tgt_q     <= '0;
    end else if (accept_i) begin
      pos_q     <= pos_d;
      held_q    <= held_d;
      unframe_q <= unframe_d;
      esc_q     <= esc_d;
      cnt_q     <= cnt_d;
      tgt_q     <= tgt_d;
    end
  end

endmodule

FILE: src/sfu_queue.sv
// ----------------------------------------------------------------------------
// sfu_queue: four-entry result queue
// Takes up to two result beats per cycle from the core and hands them out
// one per cycle on the output stream while it is ready.
// ----------------------------------------------------------------------------
module sfu_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfu_pkg::sfu_res_t         res_i,
  output logic                      room_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output sfu_pkg::sfu_beat_t        beat_o
);
  import sfu_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  sfu_beat_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d;
  logic [PtrW-1:0]   rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;
  logic [PtrW-1:0]   wr_next;

  // room for two beats means a full input beat can always be taken
  assign room_o  = (cnt_q <= CntW'(Depth - 2));
  assign valid_o = (cnt_q != '0);
  assign beat_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign wr_next = wr_q + PtrW'(1);

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q + PtrW'(res_i.num);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(res_i.num) - (pop ? CntW'(1) : CntW'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (res_i.num != 2'd0) begin
      mem_q[wr_q] <= res_i.beat0;
    end
    if (res_i.num == 2'd2) begin
      mem_q[wr_next] <= res_i.beat1;
    end
  end

endmodule

FILE: src/serial_frame_unescape_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_unescape_unit: byte unstuffing receiver for serial packets
// result beats are queued before they are offered; throughput: one input beat
// per cycle; one result beat leaves per cycle while m_axis_tready is high;
// input stalls only while the four-entry result queue has fewer than two free
// slots; reset clears packet state and the queue and loads register defaults
// ----------------------------------------------------------------------------
module serial_frame_unescape_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [sfu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sfu_pkg::CfgDataW-1:0]   cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // rx_byte, wanted_length
  input  logic                           s_axis_tuser,  // packet_start
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // out_byte
  output logic                           m_axis_tlast
);
  import sfu_pkg::*;

  sfu_cfg_t  cfg_q;
  sfu_res_t  res;
  sfu_beat_t head;
  logic      accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= ModeReset;
      cfg_q.escape <= EscapeReset;
      cfg_q.code_a <= CodeAReset;
      cfg_q.code_b <= CodeBReset;
      cfg_q.code_c <= CodeCReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAMING_MODE: cfg_q.mode   <= cfg_data_i[1:0];
        REG_ESCAPE_BYTE:  cfg_q.escape <= cfg_data_i;
        REG_CODE_A:       cfg_q.code_a <= cfg_data_i;
        REG_CODE_B:       cfg_q.code_b <= cfg_data_i;
        REG_CODE_C:       cfg_q.code_c <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode core
  sfu_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (s_axis_tdata[7:0]),
    .packet_start_i  (s_axis_tuser),
    .wanted_length_i (s_axis_tdata[15:8]),
    .cfg_i           (cfg_q),
    .res_o           (res)
  );

  // result queue
  sfu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .beat_o  (head)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tlast = head.last;

endmodule
